// ----- hdl/dpd_pkg.sv -----
// Shared types, constants and a helper function of the debug packet deframer.
`default_nettype none

package dpd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned LEN_W  = 10;
    localparam int unsigned OFF_W  = 2;
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned NUM_W  = 3;

    localparam logic [BYTE_W-1:0] CH_START = 8'h24;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_INTR  = 8'h03;
    localparam logic [BYTE_W-1:0] CH_ACK   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_NAK   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;

    localparam logic [LEN_W-1:0] LEN_MAX   = 10'd1023;
    localparam logic [OFF_W-1:0] OFF_SEQID = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_HOST     = 3'd1,
        KIND_ACCEPTED = 3'd2,
        KIND_BADSUM   = 3'd3,
        KIND_OVERFLOW = 3'd4,
        KIND_RESTART  = 3'd5,
        KIND_INTR     = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  payload_length;
        logic [OFF_W-1:0]  payload_offset;
    } t_result;

    // All results caused by one received byte; entry 0 goes out first.
    typedef struct packed {
        logic [NUM_W-1:0]                num;
        t_result [MAX_RESULTS-1:0]       res;
    } t_bundle;

    localparam t_result RESULT_NONE = '{kind: KIND_PAYLOAD, data_byte: '0,
                                        payload_length: '0, payload_offset: '0};

    // Returns {valid, value}; upper and lower case hex digits are accepted.
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dpd_ifs.sv -----
// Valid/ready channel interfaces for received bytes and deframer results.
`default_nettype none

interface dpd_byte_if;
    import dpd_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpd_result_if;
    import dpd_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  payload_length;
    logic [OFF_W-1:0]  payload_offset;
    logic              last;

    modport source (output valid, output kind, output data_byte, output payload_length,
                    output payload_offset, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input payload_length,
                    input payload_offset, input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/dpd_parser.sv -----
// Packet framing state and per-byte result decoding.
`default_nettype none

module dpd_parser #(
    parameter int unsigned BUFFER_BYTES = 1024
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_advance,
    input  wire logic [dpd_pkg::BYTE_W-1:0] i_byte,
    output dpd_pkg::t_bundle               o_bundle
);
    import dpd_pkg::*;

    localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] FULL_AT = CNT_W'(BUFFER_BYTES - 2);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CK_HI   = 2'd2,
        PH_CK_LO   = 2'd3
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [3:0]        r_hi, n_hi;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_b0, n_b0;
    logic [BYTE_W-1:0] r_b1, n_b1;
    logic              r_colon, n_colon;
    logic              r_bad, n_bad;

    logic [4:0]        hex;
    logic [31:0]       count32;
    logic [LEN_W-1:0]  len_sat;
    logic [BYTE_W-1:0] expect_sum;

    assign hex        = hex_decode(i_byte);
    assign count32    = 32'(r_count);
    assign len_sat    = (count32 > 32'd1023) ? LEN_MAX : count32[LEN_W-1:0];
    assign expect_sum = {r_hi, hex[3:0]};

    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_hi     = r_hi;
        n_count  = r_count;
        n_b0     = r_b0;
        n_b1     = r_b1;
        n_colon  = r_colon;
        n_bad    = r_bad;
        o_bundle.num = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            o_bundle.res[i] = RESULT_NONE;
        end

        unique case (r_phase)
            PH_HUNT: begin
                if (i_byte == CH_START) begin
                    n_sum = '0; n_hi = '0; n_count = '0; n_b0 = '0; n_b1 = '0;
                    n_colon = 1'b0; n_bad = 1'b0;
                    n_phase = PH_PAYLOAD;
                end else if (i_byte == CH_INTR) begin
                    o_bundle.res[0].kind = KIND_INTR;
                    o_bundle.num = 3'd1;
                end
            end
            PH_PAYLOAD: begin
                if (i_byte == CH_START) begin
                    n_sum = '0; n_hi = '0; n_count = '0; n_b0 = '0; n_b1 = '0;
                    n_colon = 1'b0; n_bad = 1'b0;
                    o_bundle.res[0].kind = KIND_RESTART;
                    o_bundle.num = 3'd1;
                end else if (i_byte == CH_HASH) begin
                    n_phase = PH_CK_HI;
                end else begin
                    if (count32 == 32'd0) begin
                        n_b0 = i_byte;
                    end
                    if (count32 == 32'd1) begin
                        n_b1 = i_byte;
                    end
                    if (count32 == 32'd2) begin
                        n_colon = (i_byte == CH_COLON);
                    end
                    n_sum   = r_sum + i_byte;
                    n_count = r_count + 1'b1;
                    o_bundle.res[0].kind      = KIND_PAYLOAD;
                    o_bundle.res[0].data_byte = i_byte;
                    o_bundle.num = 3'd1;
                    // The buffer keeps one slot spare, so the packet is dropped
                    // once it would hold all but one byte.
                    if (r_count >= FULL_AT) begin
                        o_bundle.res[1].kind = KIND_OVERFLOW;
                        o_bundle.num = 3'd2;
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_CK_HI: begin
                n_hi    = hex[3:0];
                n_bad   = r_bad | ~hex[4];
                n_phase = PH_CK_LO;
            end
            PH_CK_LO: begin
                n_bad = r_bad | ~hex[4];
                if (n_bad || expect_sum != r_sum) begin
                    o_bundle.res[0].kind      = KIND_HOST;
                    o_bundle.res[0].data_byte = CH_NAK;
                    o_bundle.res[1].kind      = KIND_BADSUM;
                    o_bundle.num = 3'd2;
                end else begin
                    o_bundle.res[0].kind      = KIND_HOST;
                    o_bundle.res[0].data_byte = CH_ACK;
                    if (count32 >= 32'd3 && r_colon) begin
                        o_bundle.res[1].kind           = KIND_HOST;
                        o_bundle.res[1].data_byte      = r_b0;
                        o_bundle.res[2].kind           = KIND_HOST;
                        o_bundle.res[2].data_byte      = r_b1;
                        o_bundle.res[3].kind           = KIND_ACCEPTED;
                        o_bundle.res[3].payload_length = len_sat;
                        o_bundle.res[3].payload_offset = OFF_SEQID;
                        o_bundle.num = 3'd4;
                    end else begin
                        o_bundle.res[1].kind           = KIND_ACCEPTED;
                        o_bundle.res[1].payload_length = len_sat;
                        o_bundle.num = 3'd2;
                    end
                end
                n_phase = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sum   <= '0;
            r_hi    <= '0;
            r_count <= '0;
            r_b0    <= '0;
            r_b1    <= '0;
            r_colon <= 1'b0;
            r_bad   <= 1'b0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_hi    <= n_hi;
            r_count <= n_count;
            r_b0    <= n_b0;
            r_b1    <= n_b1;
            r_colon <= n_colon;
            r_bad   <= n_bad;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dpd_emitter.sv -----
// Result register that sends the results of one byte out one transaction at a time.
`default_nettype none

module dpd_emitter (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire dpd_pkg::t_bundle i_bundle,
    output logic                  o_free,
    dpd_result_if.source          o_res
);
    import dpd_pkg::*;

    logic             r_valid;
    t_bundle          r_bnd;
    logic [1:0]       r_idx;
    logic [1:0]       r_last_idx;
    logic             at_last;
    t_result          cur;

    assign at_last = (r_idx == r_last_idx);
    assign o_free  = !r_valid || (o_res.ready && at_last);
    assign cur     = r_bnd.res[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_free) begin
            r_valid <= i_load && (i_bundle.num != '0);
            r_idx   <= '0;
        end else if (o_res.ready) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_bnd      <= i_bundle;
            r_last_idx <= 2'(i_bundle.num - 1'b1);
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.kind           = cur.kind;
    assign o_res.data_byte      = cur.data_byte;
    assign o_res.payload_length = cur.payload_length;
    assign o_res.payload_offset = cur.payload_offset;
    assign o_res.last           = at_last;

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind != KIND_PAYLOAD && o_res.kind != KIND_HOST)
        |-> (o_res.data_byte == '0))
        else $error("data byte set on a result that carries no byte");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.last) |=> o_res.valid)
        else $error("result sequence of one byte ended early");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_ACCEPTED || o_res.kind == KIND_BADSUM))
        |-> o_res.last)
        else $error("packet verdict was not the final result of its byte");

    a_len_only_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind != KIND_ACCEPTED)
        |-> (o_res.payload_length == '0 && o_res.payload_offset == '0))
        else $error("length or offset set outside an accepted verdict");

endmodule

`default_nettype wire

// ----- hdl/debug_packet_deframer.sv -----
// Top level of the debug packet deframer: input register, parser and result emitter.
//
// The block receives host serial bytes on i_rx, one byte per transaction, and
// recovers packets of the form '$' payload '#' followed by two hex checksum digits.
// Each byte causes zero to four results on o_res, one result per transaction, with
// last set on the final result of that byte. Payload bytes go out provisionally as
// they arrive; after the checksum the block gives the acknowledge byte for the host,
// an echoed sequence id when present, and the verdict with the payload length.
// A byte outside a packet is ignored unless it is the interrupt byte.
// A byte is held in the input register and decoded by the parser, and its first
// result is registered in the emitter's output register once the emitter is free.
// The block takes one byte per cycle while each byte yields at most one result and
// the receiver does not stall; a byte with several results occupies the output
// register until all of them are sent, since the output channel moves a single
// result per transaction.
// Reset returns the parser to hunting for a start byte and empties both registers.
// When the receiver stalls, the current result holds, the next byte waits in the
// input register, and i_rx.ready drops once that register is full.
`default_nettype none

module debug_packet_deframer #(
    parameter int unsigned BUFFER_BYTES = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    dpd_byte_if.sink      i_rx,
    dpd_result_if.source  o_res
);
    import dpd_pkg::*;

    // Input register: one received byte waiting for the parser.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              em_free;
    logic              advance;
    t_bundle           bundle;

    // The parser consumes the held byte in the same cycle the emitter can take
    // its results, so the input register frees up at once.
    assign advance    = r_in_valid && em_free;
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    dpd_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_bundle  (bundle)
    );

    dpd_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_bundle (bundle),
        .o_free   (em_free),
        .o_res    (o_res)
    );

endmodule

`default_nettype wire

// ----- verif/debug_packet_deframer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the debug packet deframer: directed framing cases, then random packets.
module debug_packet_deframer_tb;
    import dpd_pkg::*;

    localparam int unsigned BUF_BYTES    = 1024;
    localparam int unsigned RANDOM_ITEMS = 320;
    localparam int unsigned IDLE_PERCENT = 38;
    // Cycles with no transaction on either channel before the run is declared hung.
    localparam int unsigned STALL_LIMIT  = 2000;
    // Extra cycles waited after the last expected result so that stray results are caught.
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS  = 10;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] ASCII_UC_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UC_F = 8'h46;
    localparam logic [BYTE_W-1:0] ASCII_LC_A = 8'h61;
    localparam logic [BYTE_W-1:0] ASCII_LC_F = 8'h66;

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_PAYLOAD,
        ST_SUM_HI,
        ST_SUM_LO
    } t_frame_phase;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    typedef struct packed {
        t_result res;
        logic    last;
    } t_expected_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dpd_byte_if   rx_chan ();
    dpd_result_if res_chan ();

    debug_packet_deframer #(
        .BUFFER_BYTES(BUF_BYTES)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_chan),
        .o_res  (res_chan)
    );

    // Frame tracker: mirrors what the deframer must know about the packet in flight.
    t_frame_phase      rx_phase      = ST_HUNT;
    logic [BYTE_W-1:0] payload_sum   = '0;
    logic [3:0]        sum_hi_digit  = '0;
    int unsigned       payload_count = 0;
    logic [BYTE_W-1:0] seq_id [2]    = '{default: '0};
    logic              seq_colon     = 1'b0;
    logic              sum_digit_bad = 1'b0;

    // Results the deframer still owes, oldest first.
    t_expected_result pending_results[$];

    // While calm is set neither side inserts idle cycles.
    bit          calm          = 1'b0;
    int unsigned counted_items = 0;
    int unsigned fail_count    = 0;
    int unsigned stall_cycles  = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decodes one checksum character; returns 0 for anything that is not a hex digit.
    function automatic bit hex_digit(input logic [BYTE_W-1:0] c, output logic [3:0] v);
        v = '0;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            v = 4'(c - ASCII_ZERO);
        end else if (c >= ASCII_LC_A && c <= ASCII_LC_F) begin
            v = 4'(c - ASCII_LC_A + 8'd10);
        end else if (c >= ASCII_UC_A && c <= ASCII_UC_F) begin
            v = 4'(c - ASCII_UC_A + 8'd10);
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10) return ASCII_ZERO + 8'(n);
        return (upper ? ASCII_UC_A : ASCII_LC_A) + 8'(n) - 8'd10;
    endfunction

    function automatic t_result make_result(input t_kind k, input logic [BYTE_W-1:0] d,
                                            input logic [LEN_W-1:0] len,
                                            input logic [OFF_W-1:0] off);
        t_result r;
        r.kind           = k;
        r.data_byte      = d;
        r.payload_length = len;
        r.payload_offset = off;
        return r;
    endfunction

    function automatic void clear_packet();
        payload_sum   = '0;
        sum_hi_digit  = '0;
        payload_count = 0;
        seq_id[0]     = '0;
        seq_id[1]     = '0;
        seq_colon     = 1'b0;
        sum_digit_bad = 1'b0;
    endfunction

    // Advances the frame tracker by one received byte and queues the results it causes.
    function automatic void deframe_byte(input logic [BYTE_W-1:0] c);
        t_result           outs[$];
        logic [3:0]        lo_digit;
        logic [BYTE_W-1:0] sent_sum;
        logic [LEN_W-1:0]  len;
        bit                ok;
        case (rx_phase)
            ST_HUNT: begin
                if (c == CH_START) begin
                    clear_packet();
                    rx_phase = ST_PAYLOAD;
                end else if (c == CH_INTR) begin
                    outs.push_back(make_result(KIND_INTR, '0, '0, '0));
                end
            end
            ST_PAYLOAD: begin
                if (c == CH_START) begin
                    clear_packet();
                    outs.push_back(make_result(KIND_RESTART, '0, '0, '0));
                end else if (c == CH_HASH) begin
                    rx_phase = ST_SUM_HI;
                end else begin
                    if (payload_count < 2) seq_id[payload_count] = c;
                    else if (payload_count == 2) seq_colon = (c == CH_COLON);
                    payload_sum = payload_sum + c;
                    payload_count++;
                    outs.push_back(make_result(KIND_PAYLOAD, c, '0, '0));
                    // A full buffer drops the packet without any word to the host.
                    if (payload_count >= BUF_BYTES - 1) begin
                        outs.push_back(make_result(KIND_OVERFLOW, '0, '0, '0));
                        rx_phase = ST_HUNT;
                    end
                end
            end
            ST_SUM_HI: begin
                ok = hex_digit(c, sum_hi_digit);
                if (!ok) sum_digit_bad = 1'b1;
                rx_phase = ST_SUM_LO;
            end
            default: begin
                ok = hex_digit(c, lo_digit);
                if (!ok) sum_digit_bad = 1'b1;
                sent_sum = {sum_hi_digit, lo_digit};
                if (sum_digit_bad || sent_sum != payload_sum) begin
                    outs.push_back(make_result(KIND_HOST, CH_NAK, '0, '0));
                    outs.push_back(make_result(KIND_BADSUM, '0, '0, '0));
                end else begin
                    len = (payload_count > LEN_MAX) ? LEN_MAX : LEN_W'(payload_count);
                    outs.push_back(make_result(KIND_HOST, CH_ACK, '0, '0));
                    // The sequence id is echoed only when a third byte exists and is ':'.
                    if (payload_count >= 3 && seq_colon) begin
                        outs.push_back(make_result(KIND_HOST, seq_id[0], '0, '0));
                        outs.push_back(make_result(KIND_HOST, seq_id[1], '0, '0));
                        outs.push_back(make_result(KIND_ACCEPTED, '0, len, OFF_SEQID));
                    end else begin
                        outs.push_back(make_result(KIND_ACCEPTED, '0, len, '0));
                    end
                end
                rx_phase = ST_HUNT;
            end
        endcase
        foreach (outs[i]) begin
            pending_results.push_back('{res: outs[i], last: (i == outs.size() - 1)});
        end
    endfunction

    // Offers one byte, waits for its transaction and updates the prediction.
    task automatic send_byte(input logic [BYTE_W-1:0] c);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                rx_chan.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.rx_byte <= c;
        do @(posedge i_clk); while (!rx_chan.ready);
        // Bytes that the hunter merely drops do not count as traffic.
        if (!(rx_phase == ST_HUNT && c != CH_START && c != CH_INTR)) counted_items++;
        deframe_byte(c);
    endtask

    task automatic send_frame(input t_byte_q body, input logic [BYTE_W-1:0] hi_ch,
                              input logic [BYTE_W-1:0] lo_ch);
        send_byte(CH_START);
        foreach (body[i]) send_byte(body[i]);
        send_byte(CH_HASH);
        send_byte(hi_ch);
        send_byte(lo_ch);
    endtask

    function automatic logic [BYTE_W-1:0] sum_of(input t_byte_q body);
        logic [BYTE_W-1:0] s;
        s = '0;
        foreach (body[i]) s = s + body[i];
        return s;
    endfunction

    task automatic send_good(input t_byte_q body, input bit upper);
        logic [BYTE_W-1:0] s;
        s = sum_of(body);
        send_frame(body, hex_char(s[7:4], upper), hex_char(s[3:0], upper));
    endtask

    function automatic logic [BYTE_W-1:0] payload_byte();
        logic [BYTE_W-1:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_START || c == CH_HASH);
        return c;
    endfunction

    // Random payload; with_id puts ':' third so the first two bytes form a sequence id.
    function automatic t_byte_q random_body(input int unsigned n, input bit with_id);
        t_byte_q q;
        for (int unsigned i = 0; i < n; i++) begin
            if (with_id && n >= 3 && i == 2) q.push_back(CH_COLON);
            else q.push_back(payload_byte());
        end
        return q;
    endfunction

    task automatic test_idle_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_INTR);
        send_byte(CH_HASH);
        send_byte(CH_ACK);
        send_byte(CH_INTR);
    endtask

    task automatic test_accepted_packets();
        t_byte_q body;
        body = {};
        send_good(body, 1'b0);
        body = '{8'h67};
        send_good(body, 1'b0);
        body = '{8'h31, 8'h32, CH_COLON, 8'h6D};
        send_good(body, 1'b1);
        body = '{8'h61, 8'h62, CH_COLON};
        send_good(body, 1'b1);
        // Only two bytes, so the colon in second place gives no sequence id.
        body = '{8'h31, CH_COLON};
        send_good(body, 1'b0);
        // The interrupt byte inside a packet is plain payload.
        body = '{8'h00, 8'hFF, CH_INTR, 8'h80, 8'h7F};
        send_good(body, 1'b0);
    endtask

    task automatic test_checksum_errors();
        t_byte_q body;
        body = '{8'h61};
        send_frame(body, hex_char(4'h6, 1'b0), hex_char(4'h2, 1'b0));
        send_frame(body, 8'h67, hex_char(4'h1, 1'b0));
        send_frame(body, hex_char(4'h6, 1'b1), 8'h47);
        send_frame(body, CH_START, hex_char(4'h1, 1'b0));
        send_frame(body, 8'h2F, 8'h40);
    endtask

    task automatic test_restart();
        t_byte_q body;
        send_byte(CH_START);
        send_byte(8'h61);
        send_byte(8'h62);
        body = '{8'h63, 8'h64, CH_COLON, 8'h78};
        send_good(body, 1'b0);
        // Two start bytes in a row restart an empty packet.
        send_byte(CH_START);
        body = {};
        send_good(body, 1'b1);
    endtask

    // Runs without idling: a packet that fills the buffer, then the longest one accepted.
    task automatic test_buffer_limits();
        t_byte_q body;
        calm = 1'b1;
        body = random_body(BUF_BYTES - 1, 1'b0);
        send_byte(CH_START);
        foreach (body[i]) send_byte(body[i]);
        body = random_body(BUF_BYTES - 2, 1'b1);
        send_good(body, 1'b1);
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        t_byte_q           body;
        int unsigned       pick;
        int unsigned       len;
        int unsigned       n;
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] bad_ch;
        logic [3:0]        dummy;
        bit                upper;
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            pick  = $urandom_range(0, 99);
            upper = 1'($urandom_range(0, 1));
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            body  = random_body(len, 1'($urandom_range(0, 1)));
            if (pick < 50) begin
                send_good(body, upper);
            end else if (pick < 65) begin
                s = sum_of(body) ^ 8'($urandom_range(1, 255));
                send_frame(body, hex_char(s[7:4], upper), hex_char(s[3:0], upper));
            end else if (pick < 75) begin
                s = sum_of(body);
                do bad_ch = 8'($urandom_range(0, 255)); while (hex_digit(bad_ch, dummy));
                if ($urandom_range(0, 1) == 0) send_frame(body, bad_ch, hex_char(s[3:0], upper));
                else send_frame(body, hex_char(s[7:4], upper), bad_ch);
            end else if (pick < 85) begin
                // A packet cut short by a new start byte.
                send_byte(CH_START);
                n = $urandom_range(0, 3);
                repeat (n) send_byte(payload_byte());
                send_good(body, upper);
            end else begin
                // Line noise between packets, often carrying interrupts.
                n = $urandom_range(1, 4);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 40) begin
                        send_byte(CH_INTR);
                    end else begin
                        do bad_ch = 8'($urandom_range(0, 255)); while (bad_ch == CH_START);
                        send_byte(bad_ch);
                    end
                end
            end
        end
    endtask

    // Result side: random back-pressure and a compare against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_expected_result want;
        res_chan.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        if (i_rst_n && res_chan.valid && res_chan.ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result: kind %0d data %h len %0d off %0d last %b",
                             res_chan.kind, res_chan.data_byte, res_chan.payload_length,
                             res_chan.payload_offset, res_chan.last);
                end
            end else begin
                want = pending_results.pop_front();
                if (res_chan.kind !== want.res.kind ||
                    res_chan.data_byte !== want.res.data_byte ||
                    res_chan.payload_length !== want.res.payload_length ||
                    res_chan.payload_offset !== want.res.payload_offset ||
                    res_chan.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: expected kind %0d data %h len %0d off %0d last %b",
                                 want.res.kind, want.res.data_byte, want.res.payload_length,
                                 want.res.payload_offset, want.last);
                        $display("          actual   kind %0d data %h len %0d off %0d last %b",
                                 res_chan.kind, res_chan.data_byte, res_chan.payload_length,
                                 res_chan.payload_offset, res_chan.last);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_chan.valid && rx_chan.ready) || (res_chan.valid && res_chan.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        rx_chan.valid   = 1'b0;
        rx_chan.rx_byte = '0;
        res_chan.ready  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_bytes();
        test_accepted_packets();
        test_checksum_errors();
        test_restart();
        test_buffer_limits();
        test_random_traffic();

        rx_chan.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // Any stray result after the last expected one still gets caught here.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
